>>> rtl/bst_pkg.sv
// Shared types and constants for the bounded set table.
// Used by bst_ctrl and bounded_set_table_core; no dependencies.
package bst_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic             success;
    status_e          status;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

>>> rtl/bst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bst_ctrl.sv
// Sequencer for the bounded set table: one compare per cycle over the store,
// then a one-entry-per-cycle compaction on remove. Uses bst_pkg and bst_ram.
module bst_ctrl
  import bst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               res_valid_o,
  output res_t               res_o,
  input  logic               res_free_i
);

  state_e             state_q, state_d;
  logic [1:0]         op_q, op_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               success_q, success_d;
  status_e            status_q, status_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic               miss;
  logic               idx_last;

  bst_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The entry at idx_q is the last live one.
  assign idx_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    value_q   <= value_d;
    idx_q     <= idx_d;
    success_q <= success_d;
    status_q  <= status_d;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    value_d   = value_q;
    idx_d     = idx_q;
    count_d   = count_q;
    success_d = success_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q - IDX_W'(1);
    ram_wdata = ram_rdata;
    ram_raddr = idx_q + IDX_W'(1);
    miss      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        ram_raddr = '0;
        if (in_valid_i) begin
          op_d      = req_type_i;
          value_d   = value_i;
          idx_d     = '0;
          success_d = 1'b0;
          status_d  = ST_DONE;
          if (!(req_type_i == OP_ADD || req_type_i == OP_REMOVE ||
                req_type_i == OP_SEARCH)) begin
            state_d = S_RESULT;
          end else if (count_q == '0) begin
            miss = 1'b1;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (ram_rdata == value_q) begin
          case (op_q)
            OP_ADD: begin
              status_d = ST_PRESENT;
              state_d  = S_RESULT;
            end
            OP_REMOVE: begin
              success_d = 1'b1;
              if (idx_last) begin
                count_d = count_q - CNT_W'(1);
                state_d = S_RESULT;
              end else begin
                idx_d   = idx_q + IDX_W'(1);
                state_d = S_SHIFT;
              end
            end
            default: begin
              success_d = 1'b1;
              state_d   = S_RESULT;
            end
          endcase
        end else if (idx_last) begin
          miss = 1'b1;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      S_SHIFT: begin
        // Data for entry idx_q has arrived; move it down one place.
        ram_we = 1'b1;
        if (idx_last) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_RESULT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      S_RESULT: begin
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Value not in the set.
    if (miss) begin
      state_d = S_RESULT;
      if (op_d == OP_ADD) begin
        if (count_q >= CNT_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = count_q[IDX_W-1:0];
          ram_wdata = value_d;
          count_d   = count_q + CNT_W'(1);
          success_d = 1'b1;
        end
      end else begin
        status_d = ST_ABSENT;
      end
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign res_valid_o   = (state_q == S_RESULT);
  assign res_o.success = success_q;
  assign res_o.status  = status_q;
  assign res_o.count   = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_SHIFT) |-> (CNT_W'(idx_q) < count_q))
    else $error("scan index beyond live entries");

  a_no_write_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !miss) |-> !ram_we)
    else $error("store written during scan");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT) |=> $stable(count_q))
    else $error("count changed while result pending");

endmodule

>>> rtl/bounded_set_table_core.sv
// Top level of the bounded set table: request sequencer plus output register.
// Uses bst_pkg and bst_ctrl.
//
// Usage:
//   An item on the request channel (req_type_i, value_i) is accepted when
//   in_valid_i is high and in_stall_o is low. req_type 0 adds, 1 removes and
//   2 searches for value_i; code 3 leaves the set unchanged. Each item gives
//   exactly one result item (success_o, status_o, count_o) on the result
//   channel, taken when out_valid_o is high and out_stall_i is low.
//   The store is scanned one entry per cycle until the value is
//   found, and a remove then compacts the later entries one per cycle, so the
//   two together cover at most the live entries. An empty set or an unused
//   code goes straight to the result. The block takes one item at a time and
//   is stalled until the result has left the sequencer, so it cannot accept
//   a new item before it is through with the last one.
//   If the receiver stalls, the result holds in the output register while the
//   next item may already be accepted and processed; that item then waits
//   in the sequencer until the output register frees up.
//   Reset empties the set; stored values are not cleared, only the count.
module bounded_set_table_core
  import bst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               success_o,
  output logic [1:0]         status_o,
  output logic [COUNT_W-1:0] count_o
);

  logic res_valid;
  res_t res;
  logic res_free;
  logic out_valid_q, out_valid_d;
  res_t out_res_q, out_res_d;

  bst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_free_i  (res_free)
  );

  assign res_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_free) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_res_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign success_o   = out_res_q.success;
  assign status_o    = out_res_q.status;
  assign count_o     = COUNT_W'(out_res_q.count);

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_res_q)))
    else $error("stalled result item changed");

  a_success_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.success) |-> (out_res_q.status == ST_DONE))
    else $error("successful result with nonzero status");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_stall_o)
    else $error("request accepted while a result is pending");

endmodule

>>> sim/tb_bounded_set_table_core.sv
// Self-checking testbench for bounded_set_table_core: directed table, then random traffic.
// Expected results come from a behavioral model of the set kept inside this file.
// Depends on bst_pkg and the RTL under rtl/.
module tb_bounded_set_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bst_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int POOL_SIZE    = 24;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic               success;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } set_result_t;

  typedef struct {
    logic [1:0]         op;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    set_result_t        result;
  } table_row_t;

  logic               clk;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         req_type_i;
  logic [VALUE_W-1:0] value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               success_o;
  logic [1:0]         status_o;
  logic [COUNT_W-1:0] count_o;

  // Model of the set: packed entries in insertion order.
  logic [VALUE_W-1:0] model_store[CAPACITY];
  int                 model_count;

  set_result_t        pending_results[$];
  table_row_t         directed_rows[$];
  logic [VALUE_W-1:0] value_pool[POOL_SIZE];
  int                 error_count;
  int                 cycle_count;
  bit                 tx_idle_en;
  bit                 rx_idle_en;
  bit                 long_hold;

  bounded_set_table_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .success_o   (success_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic set_result_t apply_set_request(logic [1:0] op, logic [VALUE_W-1:0] v);
    set_result_t r;
    int          slot;
    int          j;
    r.success = 1'b0;
    r.status  = ST_DONE;
    slot = model_count;
    for (j = 0; j < model_count; j++) begin
      if (slot == model_count && model_store[j] == v) slot = j;
    end
    case (op)
      OP_ADD: begin
        // The presence check wins over the full check.
        if (slot < model_count) begin
          r.status = ST_PRESENT;
        end else if (model_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          model_store[model_count] = v;
          model_count++;
          r.success = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (slot < model_count) begin
          for (j = slot + 1; j < model_count; j++) model_store[j-1] = model_store[j];
          model_count--;
          r.success = 1'b1;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      OP_SEARCH: begin
        if (slot < model_count) r.success = 1'b1;
        else r.status = ST_ABSENT;
      end
      default: ;
    endcase
    r.count = model_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [1:0] random_op(int add_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return OP_UNUSED;
    if (r < 5 + add_pct) return OP_ADD;
    if ($urandom_range(0, 1) == 0) return OP_REMOVE;
    return OP_SEARCH;
  endfunction

  function automatic logic [VALUE_W-1:0] random_value(logic [1:0] op);
    int r;
    r = $urandom_range(0, 99);
    // Removes and searches often aim at a live entry so that every shift position is hit.
    if (op != OP_ADD && model_count > 0 && r < 45)
      return model_store[$urandom_range(0, model_count - 1)];
    if (r < 80) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [VALUE_W-1:0] v,
                           input bit typed, input set_result_t typed_res);
    set_result_t r;
    in_valid_i <= 1'b1;
    req_type_i <= op;
    value_i    <= v;
    do @(posedge clk); while (in_stall_o);
    r = apply_set_request(op, v);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic sender_gap();
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic run_random(int items);
    int         counted;
    int         add_pct;
    logic [1:0] op;
    logic [VALUE_W-1:0] v;
    counted = 0;
    add_pct = 45;
    while (counted < items) begin
      if (counted % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: add_pct = 25;
          1: add_pct = 45;
          default: add_pct = 70;
        endcase
      end
      op = random_op(add_pct);
      v  = random_value(op);
      send_item(op, v, 1'b0, '0);
      if (op != OP_UNUSED) counted++;
      sender_gap();
    end
  endtask

  task automatic add_row(logic [1:0] op, logic [VALUE_W-1:0] v, bit typed,
                         logic ok, status_e st, int cnt);
    table_row_t row;
    row.op             = op;
    row.value          = v;
    row.typed          = typed;
    row.result.success = ok;
    row.result.status  = st;
    row.result.count   = cnt[COUNT_W-1:0];
    directed_rows.push_back(row);
  endtask

  // Receiver: random stall bursts, one long hold on request, none in the last part.
  initial begin : receiver
    int n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        long_hold = 1'b0;
        out_stall_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    set_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected result item: success %0d status %0d count %0d",
                   success_o, status_o, count_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (success_o !== want.success || status_o !== want.status || count_o !== want.count) begin
          if (error_count < MAX_REPORTS)
            $display("result mismatch: expected success %0d status %0d count %0d, got %0d %0d %0d",
                     want.success, want.status, want.count, success_o, status_o, count_o);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_bounded_set_table_core: errors");
    $finish;
  end

  initial begin : stimulus
    int i;
    error_count = 0;
    long_hold   = 1'b0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    model_count = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    req_type_i <= OP_ADD;
    value_i    <= '0;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Empty set, unused code, extremes, duplicates, filling up and the full cases.
    add_row(OP_SEARCH, 32'h0000_0000, 1'b1, 1'b0, ST_ABSENT, 0);
    add_row(OP_REMOVE, 32'h0000_0005, 1'b1, 1'b0, ST_ABSENT, 0);
    add_row(OP_UNUSED, 32'hdead_beef, 1'b1, 1'b0, ST_DONE, 0);
    add_row(OP_ADD, 32'h8000_0000, 1'b1, 1'b1, ST_DONE, 1);
    add_row(OP_ADD, 32'h7fff_ffff, 1'b1, 1'b1, ST_DONE, 2);
    add_row(OP_ADD, 32'h8000_0000, 1'b1, 1'b0, ST_PRESENT, 2);
    add_row(OP_SEARCH, 32'h7fff_ffff, 1'b1, 1'b1, ST_DONE, 2);
    add_row(OP_ADD, 32'hffff_ffff, 1'b1, 1'b1, ST_DONE, 3);
    for (i = 1; i <= 13; i++) add_row(OP_ADD, i, 1'b1, 1'b1, ST_DONE, 3 + i);
    add_row(OP_ADD, 32'h0000_0064, 1'b1, 1'b0, ST_FULL, CAPACITY);
    add_row(OP_ADD, 32'h7fff_ffff, 1'b1, 1'b0, ST_PRESENT, CAPACITY);
    add_row(OP_REMOVE, 32'h8000_0000, 1'b1, 1'b1, ST_DONE, CAPACITY - 1);
    add_row(OP_REMOVE, 32'h0000_0006, 1'b0, 1'b0, ST_DONE, 0);
    add_row(OP_SEARCH, 32'h0000_0007, 1'b0, 1'b0, ST_DONE, 0);
    add_row(OP_REMOVE, 32'h0000_000d, 1'b0, 1'b0, ST_DONE, 0);

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].op, directed_rows[k].value,
                directed_rows[k].typed, directed_rows[k].result);
      sender_gap();
    end
    wait_drained();

    run_random(600);

    // Receiver holds off while items keep coming, so the block backs up.
    tx_idle_en = 1'b0;
    long_hold  = 1'b1;
    run_random(12);
    wait_drained();

    rx_idle_en = 1'b0;
    run_random(200);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_bounded_set_table_core: clean");
    end else begin
      $display("tb_bounded_set_table_core: errors");
    end
    $finish;
  end

endmodule
